/* rtl/core/crcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_pkg
// Shared types, constants and the bytewise CRC16-CCITT-FALSE update for the
// frame receiver.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   localparam logic [7:0]  SYNC_FIRST     = 8'hA5;
   localparam logic [7:0]  SYNC_SECOND    = 8'h5A;
   localparam logic [7:0]  TYPE_ONE       = 8'h01;
   localparam logic [7:0]  TYPE_TWO       = 8'h02;
   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_MSB        = 16'h8000;
   localparam logic [15:0] MAX_LEN_RESET  = 16'd4096;

   // Header byte positions.
   localparam logic [2:0] HDR_TYPE     = 3'd0;
   localparam logic [2:0] HDR_LEN_LO   = 3'd2;
   localparam logic [2:0] HDR_LEN_HI   = 3'd3;
   localparam logic [2:0] HDR_SEQ_LO   = 3'd4;
   localparam logic [2:0] HDR_SEQ_HI   = 3'd5;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_SYNC2  = 2'd1,
      PH_HEADER = 2'd2,
      PH_BODY   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD   = 2'd0,
      KIND_GOOD      = 2'd1,
      KIND_CRC_ERR   = 2'd2,
      KIND_HEADER_ERR = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  type_byte;
      logic [7:0]  data_byte;
      logic [15:0] sequence_res;
      logic [15:0] payload_length;
      logic        last;
      logic [31:0] good_frames;
      logic [31:0] crc_errors;
      logic [31:0] header_errors;
   } rsp_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
      logic [15:0] c;
      c = crc ^ {v, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/crcfr_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_core
// Deframer state, CRC accumulator and frame counters. One received byte is
// processed per enabled cycle and may produce one result.
// ----------------------------------------------------------------------------
module crcfr_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          rx_byte,
   input  logic [15:0]         max_length,
   output logic                res_valid,
   output crcfr_pkg::rsp_type  res
);

   crcfr_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] seq_ff, seq_in;
   logic [16:0] body_cnt_ff, body_cnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic [31:0] good_ff, good_in;
   logic [31:0] crc_err_ff, crc_err_in;
   logic [31:0] hdr_err_ff, hdr_err_in;

   logic [15:0] crc_upd;
   logic        hdr_done;
   logic        hdr_bad;
   logic        body_payload;
   logic        body_crc_lo;
   logic        crc_match;

   assign crc_upd      = crcfr_pkg::crc_byte(crc_ff, rx_byte);
   assign hdr_done     = (hdr_cnt_ff == crcfr_pkg::HDR_SEQ_HI);
   assign hdr_bad      = ((type_ff != crcfr_pkg::TYPE_ONE) && (type_ff != crcfr_pkg::TYPE_TWO))
                         || (len_ff > max_length);
   assign body_payload = (body_cnt_ff < {1'b0, len_ff});
   assign body_crc_lo  = (body_cnt_ff == {1'b0, len_ff});
   assign crc_match    = ({rx_byte, crc_lo_ff} == crc_ff);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (step_en) begin
         case (phase_ff)
            crcfr_pkg::PH_HUNT: begin
               if (rx_byte == crcfr_pkg::SYNC_FIRST) phase_in = crcfr_pkg::PH_SYNC2;
            end
            crcfr_pkg::PH_SYNC2: begin
               phase_in = (rx_byte == crcfr_pkg::SYNC_SECOND) ? crcfr_pkg::PH_HEADER
                                                              : crcfr_pkg::PH_HUNT;
            end
            crcfr_pkg::PH_HEADER: begin
               if (hdr_done) phase_in = hdr_bad ? crcfr_pkg::PH_HUNT : crcfr_pkg::PH_BODY;
            end
            crcfr_pkg::PH_BODY: begin
               if (!body_payload && !body_crc_lo) phase_in = crcfr_pkg::PH_HUNT;
            end
            default: phase_in = crcfr_pkg::PH_HUNT;
         endcase
      end
   end

   // Datapath updates and the result.
   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      type_in     = type_ff;
      len_in      = len_ff;
      seq_in      = seq_ff;
      body_cnt_in = body_cnt_ff;
      crc_in      = crc_ff;
      crc_lo_in   = crc_lo_ff;
      good_in     = good_ff;
      crc_err_in  = crc_err_ff;
      hdr_err_in  = hdr_err_ff;
      res_valid   = 1'b0;
      res.kind    = crcfr_pkg::KIND_PAYLOAD;
      res.data_byte = 8'h00;
      res.last    = 1'b0;
      if (step_en) begin
         case (phase_ff)
            crcfr_pkg::PH_HUNT: begin
            end
            crcfr_pkg::PH_SYNC2: begin
               hdr_cnt_in = 3'd0;
               crc_in     = crcfr_pkg::CRC_INIT;
            end
            crcfr_pkg::PH_HEADER: begin
               crc_in     = crc_upd;
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               case (hdr_cnt_ff)
                  crcfr_pkg::HDR_TYPE:   type_in = rx_byte;
                  crcfr_pkg::HDR_LEN_LO: len_in  = {len_ff[15:8], rx_byte};
                  crcfr_pkg::HDR_LEN_HI: len_in  = {rx_byte, len_ff[7:0]};
                  crcfr_pkg::HDR_SEQ_LO: seq_in  = {seq_ff[15:8], rx_byte};
                  crcfr_pkg::HDR_SEQ_HI: seq_in  = {rx_byte, seq_ff[7:0]};
                  default: ;
               endcase
               if (hdr_done) begin
                  if (hdr_bad) begin
                     hdr_err_in = hdr_err_ff + 32'd1;
                     res_valid  = 1'b1;
                     res.kind   = crcfr_pkg::KIND_HEADER_ERR;
                     res.last   = 1'b1;
                  end else begin
                     body_cnt_in = 17'd0;
                  end
               end
            end
            crcfr_pkg::PH_BODY: begin
               if (body_payload) begin
                  crc_in        = crc_upd;
                  body_cnt_in   = body_cnt_ff + 17'd1;
                  res_valid     = 1'b1;
                  res.kind      = crcfr_pkg::KIND_PAYLOAD;
                  res.data_byte = rx_byte;
               end else if (body_crc_lo) begin
                  crc_lo_in   = rx_byte;
                  body_cnt_in = body_cnt_ff + 17'd1;
               end else begin
                  res_valid = 1'b1;
                  res.last  = 1'b1;
                  if (crc_match) begin
                     good_in  = good_ff + 32'd1;
                     res.kind = crcfr_pkg::KIND_GOOD;
                  end else begin
                     crc_err_in = crc_err_ff + 32'd1;
                     res.kind   = crcfr_pkg::KIND_CRC_ERR;
                  end
               end
            end
            default: ;
         endcase
      end
      // Fields reflect the state after this byte's update.
      res.type_byte      = type_in;
      res.sequence_res   = seq_in;
      res.payload_length = len_in;
      res.good_frames    = good_in;
      res.crc_errors     = crc_err_in;
      res.header_errors  = hdr_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= crcfr_pkg::PH_HUNT;
         hdr_cnt_ff  <= 3'd0;
         type_ff     <= 8'h00;
         len_ff      <= 16'h0000;
         seq_ff      <= 16'h0000;
         body_cnt_ff <= 17'd0;
         crc_ff      <= crcfr_pkg::CRC_INIT;
         crc_lo_ff   <= 8'h00;
         good_ff     <= 32'd0;
         crc_err_ff  <= 32'd0;
         hdr_err_ff  <= 32'd0;
      end else begin
         phase_ff    <= phase_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         type_ff     <= type_in;
         len_ff      <= len_in;
         seq_ff      <= seq_in;
         body_cnt_ff <= body_cnt_in;
         crc_ff      <= crc_in;
         crc_lo_ff   <= crc_lo_in;
         good_ff     <= good_in;
         crc_err_ff  <= crc_err_in;
         hdr_err_ff  <= hdr_err_in;
      end
   end

endmodule

/* rtl/core/crcfr_skid.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfr_skid
// Output register with a skid entry, so a result can be captured while the
// previous one still waits on the result channel.
// ----------------------------------------------------------------------------
module crcfr_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  crcfr_pkg::rsp_type  in_data,
   output logic                in_ready,
   output logic                out_valid,
   input  logic                out_ready,
   output crcfr_pkg::rsp_type  out_data
);

   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   crcfr_pkg::rsp_type out_data_ff, out_data_in;
   crcfr_pkg::rsp_type skid_data_ff, skid_data_in;
   logic               out_free;

   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // A new result only arrives while the skid entry is empty.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

/* rtl/core/crc16_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// Throughput: one byte per cycle unless the output register and skid entry are full;
// the deframer step and CRC byte update are one registered stage, and a skid entry
// keeps bytes flowing while one result is stalled.
// Reset (synchronous, active high) returns to sync hunting, sets the CRC to FFFF,
// clears all counters and held header fields, and sets max_length to 4096.
// ----------------------------------------------------------------------------
// crc16_frame_receiver_unit
// Byte-serial A5 5A framed receiver with header check, payload streaming and
// CRC16-CCITT-FALSE verification.
// ----------------------------------------------------------------------------
module crc16_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_type_byte,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_sequence_res,
   output logic [15:0] rsp_payload_length,
   output logic        rsp_last,
   output logic [31:0] rsp_good_frames,
   output logic [31:0] rsp_crc_errors,
   output logic [31:0] rsp_header_errors,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_length
);

   logic [15:0]        max_len_ff, max_len_in;
   logic               step_en;
   logic               res_valid;
   crcfr_pkg::rsp_type res;
   crcfr_pkg::rsp_type rsp;

   assign csr_ready = 1'b1;
   assign step_en   = req_valid && req_ready;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_valid) max_len_in = csr_max_length;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= crcfr_pkg::MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   crcfr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .rx_byte    (req_rx_byte),
      .max_length (max_len_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   crcfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp)
   );

   assign rsp_kind           = rsp.kind;
   assign rsp_type_byte      = rsp.type_byte;
   assign rsp_data_byte      = rsp.data_byte;
   assign rsp_sequence_res   = rsp.sequence_res;
   assign rsp_payload_length = rsp.payload_length;
   assign rsp_last           = rsp.last;
   assign rsp_good_frames    = rsp.good_frames;
   assign rsp_crc_errors     = rsp.crc_errors;
   assign rsp_header_errors  = rsp.header_errors;

   // Input stalls only when both the output register and the skid entry hold results.
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled while no result is pending");

   // After a result is accepted into the pipe, the output must hold a valid result in the next cycle.
   a_result_appears: assert property (@(posedge clock) disable iff (reset)
      (step_en && res_valid) |=> rsp_valid)
      else $error("result of an accepted byte did not reach the output");

   // Only verdict transactions close a frame attempt.
   a_last_on_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != crcfr_pkg::KIND_PAYLOAD)))
      else $error("last flag does not match result kind");

   // Payload bytes are zero on verdict transactions.
   a_verdict_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_data_byte == 8'h00))
      else $error("verdict carries a nonzero data byte");

endmodule

/* dv/tb_crc16_frame_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crc16_frame_receiver_unit
// Self-checking bench for the A5 5A framed receiver. A byte-level predictor
// tracks sync hunting, header checks, payload streaming and the CRC16 verdict.
// Each result transaction is compared against the oldest predicted result.
// Directed frames cover the corner cases. Random traffic then mixes valid
// frames, header errors, noise and broken sync under several idle and stall
// patterns and max_length settings.
// ----------------------------------------------------------------------------
module tb_crc16_frame_receiver_unit;

   localparam int QUIET_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_type_byte;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_sequence_res;
   logic [15:0] rsp_payload_length;
   logic        rsp_last;
   logic [31:0] rsp_good_frames;
   logic [31:0] rsp_crc_errors;
   logic [31:0] rsp_header_errors;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_length = 16'h0000;

   // Predictor state for the deframer.
   crcfr_pkg::phase_type rx_phase;
   logic [2:0]  hdr_pos;
   logic [7:0]  hdr_type;
   logic [15:0] hdr_len;
   logic [15:0] hdr_seq;
   logic [16:0] body_idx;
   logic [15:0] crc_acc;
   logic [7:0]  crc_lo;
   logic [31:0] n_good;
   logic [31:0] n_crc_err;
   logic [31:0] n_hdr_err;
   logic [15:0] max_len_cfg = crcfr_pkg::MAX_LEN_RESET;

   crcfr_pkg::rsp_type pending_rsp[$];
   crcfr_pkg::rsp_type want;
   int          mismatches = 0;
   int          bytes_sent = 0;
   int          quiet_cycles = 0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   logic        hold_rsp = 1'b0;

   crc16_frame_receiver_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_type_byte      (rsp_type_byte),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last           (rsp_last),
      .rsp_good_frames    (rsp_good_frames),
      .rsp_crc_errors     (rsp_crc_errors),
      .rsp_header_errors  (rsp_header_errors),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_length     (csr_max_length)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Bit-serial form of the CCITT update, MSB first.
   function automatic logic [15:0] crc_ccitt_step(input logic [15:0] crc,
                                                  input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[15] ^ b[i];
         crc = {crc[14:0], 1'b0} ^ (fb ? crcfr_pkg::CRC_POLY : 16'h0000);
      end
      return crc;
   endfunction

   function automatic void queue_result(input crcfr_pkg::kind_type k,
                                        input logic [7:0] data);
      crcfr_pkg::rsp_type r;
      r.kind           = k;
      r.type_byte      = hdr_type;
      r.data_byte      = data;
      r.sequence_res   = hdr_seq;
      r.payload_length = hdr_len;
      r.last           = (k != crcfr_pkg::KIND_PAYLOAD);
      r.good_frames    = n_good;
      r.crc_errors     = n_crc_err;
      r.header_errors  = n_hdr_err;
      pending_rsp.push_back(r);
   endfunction

   function automatic void deframe_byte(input logic [7:0] b);
      case (rx_phase)
         crcfr_pkg::PH_HUNT: begin
            if (b == crcfr_pkg::SYNC_FIRST) rx_phase = crcfr_pkg::PH_SYNC2;
         end
         crcfr_pkg::PH_SYNC2: begin
            rx_phase = (b == crcfr_pkg::SYNC_SECOND) ? crcfr_pkg::PH_HEADER
                                                     : crcfr_pkg::PH_HUNT;
            hdr_pos  = 3'd0;
            crc_acc  = crcfr_pkg::CRC_INIT;
         end
         crcfr_pkg::PH_HEADER: begin
            crc_acc = crc_ccitt_step(crc_acc, b);
            case (hdr_pos)
               crcfr_pkg::HDR_TYPE:   hdr_type = b;
               crcfr_pkg::HDR_LEN_LO: hdr_len[7:0] = b;
               crcfr_pkg::HDR_LEN_HI: hdr_len[15:8] = b;
               crcfr_pkg::HDR_SEQ_LO: hdr_seq[7:0] = b;
               crcfr_pkg::HDR_SEQ_HI: hdr_seq[15:8] = b;
               default: ;
            endcase
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == 3'd6) begin
               if ((hdr_type != crcfr_pkg::TYPE_ONE && hdr_type != crcfr_pkg::TYPE_TWO) ||
                   hdr_len > max_len_cfg) begin
                  n_hdr_err = n_hdr_err + 32'd1;
                  rx_phase  = crcfr_pkg::PH_HUNT;
                  queue_result(crcfr_pkg::KIND_HEADER_ERR, 8'h00);
               end else begin
                  body_idx = 17'd0;
                  rx_phase = crcfr_pkg::PH_BODY;
               end
            end
         end
         default: begin
            if (body_idx < {1'b0, hdr_len}) begin
               crc_acc  = crc_ccitt_step(crc_acc, b);
               body_idx = body_idx + 17'd1;
               queue_result(crcfr_pkg::KIND_PAYLOAD, b);
            end else if (body_idx == {1'b0, hdr_len}) begin
               crc_lo   = b;
               body_idx = body_idx + 17'd1;
            end else begin
               rx_phase = crcfr_pkg::PH_HUNT;
               if ({b, crc_lo} == crc_acc) begin
                  n_good = n_good + 32'd1;
                  queue_result(crcfr_pkg::KIND_GOOD, 8'h00);
               end else begin
                  n_crc_err = n_crc_err + 32'd1;
                  queue_result(crcfr_pkg::KIND_CRC_ERR, 8'h00);
               end
            end
         end
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, name, exp_val, act_val);
         mismatches++;
      end
   endtask

   // Prediction and checking, all sampled at the rising edge.
   always @(posedge clock) begin
      if (reset) begin
         rx_phase    = crcfr_pkg::PH_HUNT;
         hdr_pos     = 3'd0;
         hdr_type    = 8'h00;
         hdr_len     = 16'h0000;
         hdr_seq     = 16'h0000;
         body_idx    = 17'd0;
         crc_acc     = crcfr_pkg::CRC_INIT;
         crc_lo      = 8'h00;
         n_good      = 32'd0;
         n_crc_err   = 32'd0;
         n_hdr_err   = 32'd0;
         max_len_cfg = crcfr_pkg::MAX_LEN_RESET;
         pending_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t ns: unexpected result transaction, kind %0d data %0h",
                        $time, rsp_kind, rsp_data_byte);
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_kind));
               check_field("type_byte", 32'(want.type_byte), 32'(rsp_type_byte));
               check_field("data_byte", 32'(want.data_byte), 32'(rsp_data_byte));
               check_field("sequence_res", 32'(want.sequence_res),
                           32'(rsp_sequence_res));
               check_field("payload_length", 32'(want.payload_length),
                           32'(rsp_payload_length));
               check_field("last", 32'(want.last), 32'(rsp_last));
               check_field("good_frames", want.good_frames, rsp_good_frames);
               check_field("crc_errors", want.crc_errors, rsp_crc_errors);
               check_field("header_errors", want.header_errors, rsp_header_errors);
            end
         end
         if (csr_valid && csr_ready) max_len_cfg = csr_max_length;
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
      end
   end

   // Watchdog on cycles with no transaction on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   // A header that the block rejects is sent without payload or CRC.
   task automatic send_packet(input logic [7:0] ftype, input logic [15:0] len,
                              input logic [15:0] seq, input bit bad_crc);
      logic [7:0]  hdr [6];
      logic [15:0] crc;
      logic [7:0]  b;
      hdr = '{ftype, 8'($urandom), len[7:0], len[15:8], seq[7:0], seq[15:8]};
      crc = crcfr_pkg::CRC_INIT;
      send_byte(crcfr_pkg::SYNC_FIRST);
      send_byte(crcfr_pkg::SYNC_SECOND);
      foreach (hdr[i]) begin
         crc = crc_ccitt_step(crc, hdr[i]);
         send_byte(hdr[i]);
      end
      if ((ftype != crcfr_pkg::TYPE_ONE && ftype != crcfr_pkg::TYPE_TWO) ||
          len > max_len_cfg) return;
      repeat (len) begin
         b   = 8'($urandom);
         crc = crc_ccitt_step(crc, b);
         send_byte(b);
      end
      if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
   endtask

   // The last byte sent may produce no result, so the task waits after the
   // final expected result before the register is written.
   task automatic write_max_length(input logic [15:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_max_length <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_sync_hunt;
      send_byte(8'h12);
      send_byte(crcfr_pkg::SYNC_FIRST);
      send_byte(crcfr_pkg::SYNC_FIRST);
      send_byte(crcfr_pkg::SYNC_SECOND);
      send_byte(crcfr_pkg::SYNC_FIRST);
      send_byte(8'h33);
   endtask

   task automatic test_zero_length_frame;
      send_packet(crcfr_pkg::TYPE_TWO, 16'h0000, 16'hFFFF, 1'b0);
   endtask

   task automatic test_header_errors;
      send_packet(8'h00, 16'h0001, 16'h0000, 1'b0);
      send_packet(8'hFF, 16'h0000, 16'h1234, 1'b0);
      send_packet(crcfr_pkg::TYPE_ONE, crcfr_pkg::MAX_LEN_RESET + 16'd1, 16'h8001, 1'b0);
   endtask

   task automatic test_crc_error;
      send_packet(crcfr_pkg::TYPE_ONE, 16'h0001, 16'h0000, 1'b1);
   endtask

   task automatic test_max_length_extremes;
      write_max_length(16'h0000);
      send_packet(crcfr_pkg::TYPE_ONE, 16'h0000, 16'h00FF, 1'b0);
      send_packet(crcfr_pkg::TYPE_ONE, 16'h0001, 16'hFF00, 1'b0);
      write_max_length(16'hFFFF);
      send_packet(crcfr_pkg::TYPE_TWO, 16'h0003, 16'h5555, 1'b0);
   endtask

   // The result side holds off while a long frame keeps arriving, so the
   // block fills and has to stall its input.
   task automatic test_backpressure;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      fork
         begin
            @(posedge clock);
            hold_rsp = 1'b1;
            repeat (80) @(posedge clock);
            hold_rsp = 1'b0;
         end
         send_packet(crcfr_pkg::TYPE_ONE, 16'd40, 16'hA55A, 1'b0);
      join
   endtask

   task automatic run_traffic(input int n_bytes);
      int          stop_at;
      int          pick;
      logic [15:0] len;
      logic [7:0]  t;
      stop_at = bytes_sent + n_bytes;
      while (bytes_sent < stop_at) begin
         pick = int'($urandom_range(99));
         if (pick < 70) begin
            if ($urandom_range(9) == 0 && max_len_cfg <= 16'd60) begin
               len = max_len_cfg;
            end else if ($urandom_range(99) < 85) begin
               len = 16'($urandom_range(0, (max_len_cfg < 16'd12) ? max_len_cfg : 16'd12));
            end else begin
               len = 16'($urandom_range(13, 60));
            end
            send_packet(8'($urandom_range(1, 2)), len, 16'($urandom),
                        $urandom_range(99) < 15);
         end else if (pick < 80) begin
            if (max_len_cfg == 16'hFFFF || $urandom_range(1) == 0) begin
               t = 8'($urandom_range(2, 255));
               if (t == crcfr_pkg::TYPE_TWO) t = 8'h00;
               send_packet(t, 16'($urandom), 16'($urandom), 1'b0);
            end else begin
               send_packet(8'($urandom_range(1, 2)),
                           16'($urandom_range({16'h0000, max_len_cfg} + 32'd1, 65535)),
                           16'($urandom), 1'b0);
            end
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
         end else begin
            send_byte(crcfr_pkg::SYNC_FIRST);
            if ($urandom_range(1) == 0) begin
               t = 8'($urandom);
               if (t == crcfr_pkg::SYNC_SECOND) t = crcfr_pkg::SYNC_FIRST;
               send_byte(t);
            end else begin
               // Cut-off frame: the following bytes are taken as its header.
               send_byte(crcfr_pkg::SYNC_SECOND);
               repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            end
         end
      end
   endtask

   task automatic test_random_traffic;
      write_max_length(16'hFFFF);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_traffic(340);
      write_max_length(16'd20);
      send_idle_pct = 52;
      rsp_stall_pct = 0;
      run_traffic(340);
      write_max_length(16'h0000);
      send_idle_pct = 0;
      rsp_stall_pct = 52;
      run_traffic(300);
      write_max_length(crcfr_pkg::MAX_LEN_RESET);
      send_idle_pct = 27;
      rsp_stall_pct = 27;
      run_traffic(340);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_sync_hunt();
      test_zero_length_frame();
      test_header_errors();
      test_crc_error();
      test_max_length_extremes();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
